>>> src/sba_pkg.sv
// ---------------------------------------------------------------------------
// sba_pkg
// Shared types and operation codes for the signed byte ALU.
// ---------------------------------------------------------------------------
package sba_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Operand width, fixed by the channel payloads
  localparam int unsigned OperandW = 8;

  // Field widths of the channels
  localparam int unsigned FieldW  = OperandW;
  localparam int unsigned ResultW = 2 * OperandW;

  typedef struct packed {
    op_e                      operation;
    logic signed [FieldW-1:0] operand_a;
    logic signed [FieldW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [ResultW-1:0] result;
    logic signed [FieldW-1:0]  remainder;
    logic                      overflow;
    logic                      divide_by_zero;
  } rsp_t;

endpackage

>>> src/sba_if.sv
// ---------------------------------------------------------------------------
// sba_req_if / sba_rsp_if
// Valid/ready channels that carry request and response beats.
// ---------------------------------------------------------------------------
interface sba_req_if
  import sba_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sba_rsp_if
  import sba_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/sba_cell.sv
// ---------------------------------------------------------------------------
// sba_cell
// One stage of the arithmetic chain: one Booth step on the product and one
// restoring step on the quotient, then hands its state to the next cell.
// ---------------------------------------------------------------------------
module sba_cell
  import sba_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W-1:0]   mcand_i,   // multiplicand
  input  logic [2*W+1:0] prod_i,    // {acc, multiplier, booth bit}
  input  logic [W-1:0]   dvs_i,     // divisor magnitude
  input  logic [W-1:0]   rem_i,     // partial remainder
  input  logic [W-1:0]   quo_i,     // dividend bits shifted into quotient
  input  rsp_t           side_i,    // add/sub result and flags riding along
  input  logic [2:0]     ctl_i,     // {neg quotient, neg remainder, special}
  output logic           valid_o,
  output logic [W-1:0]   mcand_o,
  output logic [2*W+1:0] prod_o,
  output logic [W-1:0]   dvs_o,
  output logic [W-1:0]   rem_o,
  output logic [W-1:0]   quo_o,
  output rsp_t           side_o,
  output logic [2:0]     ctl_o
);

  logic [W:0]     acc, acc_add;
  logic [2*W+1:0] prod_d;
  logic [W:0]     trial;
  logic [W-1:0]   rem_sh, rem_d, quo_d;

  // Booth radix-2 step with a sign-widened accumulator, then arithmetic shift
  always_comb begin
    acc = prod_i[2*W+1:W+1];
    case (prod_i[1:0])
      2'b01:   acc_add = acc + {mcand_i[W-1], mcand_i};
      2'b10:   acc_add = acc - {mcand_i[W-1], mcand_i};
      default: acc_add = acc;
    endcase
    prod_d = {acc_add[W], acc_add, prod_i[W:1]};
  end

  // Restoring divide step
  always_comb begin
    rem_sh = {rem_i[W-2:0], quo_i[W-1]};
    trial  = {rem_i[W-1], rem_sh} - {1'b0, dvs_i};
    if (!trial[W]) begin
      rem_d = trial[W-1:0];
      quo_d = {quo_i[W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      quo_d = {quo_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mcand_o <= mcand_i;
      prod_o  <= prod_d;
      dvs_o   <= dvs_i;
      rem_o   <= rem_d;
      quo_o   <= quo_d;
      side_o  <= side_i;
      ctl_o   <= ctl_i;
    end
  end

endmodule

>>> src/signed_byte_alu_booth_restoring.sv
// ---------------------------------------------------------------------------
// signed_byte_alu_booth_restoring
// Signed ALU: add, subtract, Booth multiply, restoring divide.
// ---------------------------------------------------------------------------
// Fully pipelined: one beat is accepted every cycle that the chain advances. A
// beat is loaded into the input stage register at the accepting edge, then
// passes a chain of OperandW cells each doing one Booth step and one
// restoring-divide step, then one output stage. The whole chain advances
// together and stalls only when the output register holds a beat that the
// sink has not taken. The operand width is the package constant OperandW.
module signed_byte_alu_booth_restoring
  import sba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sba_req_if.sink   req_i,
  sba_rsp_if.source rsp_o
);

  localparam int unsigned W = OperandW;

  logic en;
  logic [W:0]          v;
  logic [W:0][W-1:0]   mcand, dvs, rem, quo;
  logic [W:0][2*W+1:0] prod;
  rsp_t [W:0]          side;
  logic [W:0][2:0]     ctl;

  logic               out_vld_q;
  rsp_t               out_q;

  // Chain advances when the output slot is free or being taken
  assign en          = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  // Input stage: operand decode, add/sub and divide special cases
  logic signed [W-1:0] a, b;
  logic signed [W:0]   sum;
  logic                sum_ovf, a_min, b_m1, b_zero;
  logic [W-1:0]        ma, mb;
  rsp_t                side_d;
  logic [2:0]          ctl_d;

  always_comb begin
    a      = req_i.payload.operand_a[W-1:0];
    b      = req_i.payload.operand_b[W-1:0];
    ma     = a[W-1] ? W'(-a) : W'(a);
    mb     = b[W-1] ? W'(-b) : W'(b);
    a_min  = a == {1'b1, {(W-1){1'b0}}};
    b_m1   = &b;
    b_zero = b == '0;
    if (req_i.payload.operation == OP_SUB) sum = {a[W-1], a} - {b[W-1], b};
    else                                   sum = {a[W-1], a} + {b[W-1], b};
    sum_ovf = sum[W] != sum[W-1];
    side_d  = '0;
    ctl_d   = 3'b000;
    case (req_i.payload.operation)
      OP_ADD, OP_SUB: begin
        ctl_d[0]        = 1'b1;
        side_d.overflow = sum_ovf;
        if (!sum_ovf) side_d.result = ResultW'($signed(sum[W-1:0]));
      end
      OP_MUL: ;
      OP_DIV: begin
        if (b_zero) begin
          ctl_d[0]              = 1'b1;
          side_d.divide_by_zero = 1'b1;
          side_d.result         = '1;
          side_d.remainder      = FieldW'($signed(a));
        end else if (a_min && b_m1) begin
          ctl_d[0]        = 1'b1;
          side_d.overflow = 1'b1;
        end else begin
          ctl_d[2] = a[W-1] ^ b[W-1];
          ctl_d[1] = a[W-1];
        end
      end
      default: ;
    endcase
  end

  logic op_mul_q;
  logic [W-1:0] op_mul_sr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mcand[0] <= a;
      prod[0]  <= {{(W+1){1'b0}}, b, 1'b0};
      dvs[0]   <= mb;
      rem[0]   <= '0;
      quo[0]   <= ma;
      side[0]  <= side_d;
      ctl[0]   <= ctl_d;
      op_mul_q <= req_i.payload.operation == OP_MUL;
    end
  end

  // Operation class rides alongside the chain
  always_ff @(posedge clk_i) begin
    if (en) op_mul_sr_q <= {op_mul_sr_q[W-2:0], op_mul_q};
  end

  // Chain of cells
  for (genvar i = 0; i < W; i++) begin : g_cell
    sba_cell #(.W(W)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v[i]), .mcand_i(mcand[i]), .prod_i(prod[i]), .dvs_i(dvs[i]),
      .rem_i(rem[i]), .quo_i(quo[i]), .side_i(side[i]), .ctl_i(ctl[i]),
      .valid_o(v[i+1]), .mcand_o(mcand[i+1]), .prod_o(prod[i+1]),
      .dvs_o(dvs[i+1]), .rem_o(rem[i+1]), .quo_o(quo[i+1]),
      .side_o(side[i+1]), .ctl_o(ctl[i+1])
    );
  end

  // Output stage: pick the result source and apply signs
  rsp_t out_d;
  logic [2*W-1:0] pr;
  logic [W-1:0]   q, r;
  always_comb begin
    pr    = prod[W][2*W:1];
    q     = ctl[W][2] ? W'(-quo[W]) : quo[W];
    r     = ctl[W][1] ? W'(-rem[W]) : rem[W];
    out_d = '0;
    if (ctl[W][0]) begin
      out_d = side[W];
    end else if (op_mul_sr_q[W-1]) begin
      out_d.result = ResultW'($signed(pr));
    end else begin
      out_d.result    = ResultW'($signed(q));
      out_d.remainder = FieldW'($signed(r));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

`ifndef SYNTHESIS
  // A held output beat must not change while stalled by the sink
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(out_q))
    else $error("output beat changed while stalled");
  // Input is taken exactly when the chain advances
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> v[0])
    else $error("accepted beat not captured");
  // Divide by zero and overflow never both set
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.overflow && out_q.divide_by_zero))
    else $error("conflicting flags");
`endif

endmodule
